@@ rtl/bracket_stack_matcher_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BRACKET_STACK_MATCHER_DEFINES_SVH
`define BRACKET_STACK_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsm_pkg.sv @@
package bsm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    localparam int SYMBOL_W  = 8;
    localparam int KIND_W    = 2;
    localparam int WEIGHT_W  = 16;
    localparam int RADIX_W   = 8;
    localparam int SCORE_W   = 64;
    localparam int NUM_KINDS = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int OUT_BITS   = 1 + KIND_W + WEIGHT_W + SCORE_W + SCORE_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ROUND     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SQUARE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CURLY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ANGLE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLETION_RADIX = 3'd4;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ROUND  = 16'd3;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_SQUARE = 16'd57;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CURLY  = 16'd1197;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ANGLE  = 16'd25137;
    localparam logic [RADIX_W-1:0]  RST_RADIX         = 8'd5;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

    localparam logic [SYMBOL_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [SYMBOL_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [SYMBOL_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [SYMBOL_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } bsm_decode_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KIND_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } bsm_ram_req_t;

    function automatic bsm_decode_t open_decode(input logic [SYMBOL_W-1:0] sym);
        bsm_decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_ROUND;
        unique case (sym)
            CH_OPEN_ROUND:  d.kind = KIND_ROUND;
            CH_OPEN_SQUARE: d.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  d.kind = KIND_CURLY;
            CH_OPEN_ANGLE:  d.kind = KIND_ANGLE;
            default:        d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic bsm_decode_t close_decode(input logic [SYMBOL_W-1:0] sym);
        bsm_decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_ROUND;
        unique case (sym)
            CH_CLOSE_ROUND:  d.kind = KIND_ROUND;
            CH_CLOSE_SQUARE: d.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  d.kind = KIND_CURLY;
            CH_CLOSE_ANGLE:  d.kind = KIND_ANGLE;
            default:         d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/bracket_stack_matcher.sv @@
// Symbol beats are taken back to back, one per cycle while s_tready is high, with push and pop
// on a two-port stack RAM. A line-end beat stalls input while the RAM is walked from the top,
// one entry per cycle through the radix multiplier; an empty or corrupt line skips the walk.
// The result beat is valid as input resumes and stays until taken; a line end waits for it.
// rst_n clears the stack level, line flags, error total and output valid at once and
// loads the default weights and radix; the stack RAM itself is not cleared.
module bracket_stack_matcher
    import bsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYMBOL_W-1:0]    s_tdata,   // [7:0] symbol
    input  logic                   s_tuser,   // [0] has_symbol
    input  logic                   s_tlast,   // line_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] line_corrupt, [2:1] bad_kind, [18:3] line_error_weight,
    // [82:19] completion_score, [146:83] total_error_score, [147] stack_overflowed
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                  state_reg, state_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  line_bad_reg, line_bad_next;
    logic [KIND_W-1:0]     bad_kind_reg, bad_kind_next;
    logic                  ovf_reg, ovf_next;
    logic [SCORE_W-1:0]    err_total_reg, err_total_next;
    logic [KIND_W-1:0]     top_kind_reg, top_kind_next;
    logic                  top_in_ram_reg, top_in_ram_next;
    logic [LEVEL_W-1:0]    walk_idx_reg, walk_idx_next;
    logic                  rd_pending_reg, rd_pending_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WEIGHT_W-1:0]   weight_reg [NUM_KINDS];
    logic [RADIX_W-1:0]    radix_reg;
    logic [SCORE_W-1:0]    score_reg, score_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    bsm_decode_t           op_dec, cl_dec;
    bsm_ram_req_t          ram_req;
    logic [KIND_W-1:0]     ram_rd_data;
    logic [KIND_W-1:0]     top_kind;
    logic [LEVEL_W-1:0]    level_m2, walk_m1;
    logic                  in_fire, active, full;
    logic                  do_push, do_drop, do_pop, mismatch;
    logic                  walk_rd, walk_done, emit;

    bsm_stack_ram u_stack_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign op_dec   = open_decode(s_tdata);
    assign cl_dec   = close_decode(s_tdata);
    assign active   = in_fire && s_tuser && !line_bad_reg;
    assign full     = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign top_kind = top_in_ram_reg ? ram_rd_data : top_kind_reg;

    assign do_push  = active && op_dec.hit && !full;
    assign do_drop  = active && op_dec.hit && full;
    assign mismatch = active && cl_dec.hit
                      && ((level_reg == '0) || (top_kind != cl_dec.kind));
    assign do_pop   = active && cl_dec.hit && !mismatch;

    assign walk_rd   = (state_reg == ST_WALK) && (walk_idx_reg != '0);
    assign walk_done = (state_reg == ST_WALK) && (walk_idx_reg == '0) && !rd_pending_reg;
    assign emit      = walk_done && (!out_valid_reg || m_tready);

    assign level_m2 = level_reg - LEVEL_W'(2);
    assign walk_m1  = walk_idx_reg - LEVEL_W'(1);

    always_comb
    begin
        ram_req.wr_en   = do_push;
        ram_req.wr_addr = level_reg[ADDR_W-1:0];
        ram_req.wr_data = op_dec.kind;
        ram_req.rd_en   = do_pop || walk_rd;
        ram_req.rd_addr = walk_rd ? walk_m1[ADDR_W-1:0] : level_m2[ADDR_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        line_bad_next   = line_bad_reg;
        bad_kind_next   = bad_kind_reg;
        ovf_next        = ovf_reg;
        err_total_next  = err_total_reg;
        top_kind_next   = top_kind_reg;
        top_in_ram_next = top_in_ram_reg;
        walk_idx_next   = walk_idx_reg;
        rd_pending_next = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        score_next      = score_reg;
        out_data_next   = out_data_reg;

        if (do_push)
        begin
            level_next      = level_reg + LEVEL_W'(1);
            top_kind_next   = op_dec.kind;
            top_in_ram_next = 1'b0;
        end
        if (do_pop)
        begin
            level_next      = level_reg - LEVEL_W'(1);
            top_in_ram_next = 1'b1;
        end
        if (do_drop)
        begin
            ovf_next = 1'b1;
        end
        if (mismatch)
        begin
            line_bad_next  = 1'b1;
            bad_kind_next  = cl_dec.kind;
            err_total_next = err_total_reg + SCORE_W'(weight_reg[cl_dec.kind]);
        end
        if (in_fire && s_tlast)
        begin
            state_next    = ST_WALK;
            walk_idx_next = line_bad_next ? '0 : level_next;
            score_next    = '0;
        end

        // walk the stack top down, one entry per cycle
        if (walk_rd)
        begin
            walk_idx_next   = walk_m1;
            rd_pending_next = 1'b1;
        end
        if (rd_pending_reg)
        begin
            score_next = SCORE_W'(score_reg * SCORE_W'(radix_reg))
                         + SCORE_W'(ram_rd_data) + SCORE_W'(1);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[0]     = line_bad_reg;
            out_data_next[2:1]   = line_bad_reg ? bad_kind_reg : KIND_ROUND;
            out_data_next[18:3]  = line_bad_reg ? weight_reg[bad_kind_reg] : '0;
            out_data_next[82:19] = line_bad_reg ? '0 : score_reg;
            out_data_next[146:83] = err_total_reg;
            out_data_next[147]   = ovf_reg;
            level_next    = '0;
            line_bad_next = 1'b0;
            bad_kind_next = KIND_ROUND;
            ovf_next      = 1'b0;
            state_next    = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            line_bad_reg   <= 1'b0;
            bad_kind_reg   <= KIND_ROUND;
            ovf_reg        <= 1'b0;
            err_total_reg  <= '0;
            top_kind_reg   <= KIND_ROUND;
            top_in_ram_reg <= 1'b0;
            walk_idx_reg   <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            line_bad_reg   <= line_bad_next;
            bad_kind_reg   <= bad_kind_next;
            ovf_reg        <= ovf_next;
            err_total_reg  <= err_total_next;
            top_kind_reg   <= top_kind_next;
            top_in_ram_reg <= top_in_ram_next;
            walk_idx_reg   <= walk_idx_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg[KIND_ROUND]  <= RST_WEIGHT_ROUND;
            weight_reg[KIND_SQUARE] <= RST_WEIGHT_SQUARE;
            weight_reg[KIND_CURLY]  <= RST_WEIGHT_CURLY;
            weight_reg[KIND_ANGLE]  <= RST_WEIGHT_ANGLE;
            radix_reg               <= RST_RADIX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT_ROUND:     weight_reg[KIND_ROUND]  <= cfg_data;
                REG_WEIGHT_SQUARE:    weight_reg[KIND_SQUARE] <= cfg_data;
                REG_WEIGHT_CURLY:     weight_reg[KIND_CURLY]  <= cfg_data;
                REG_WEIGHT_ANGLE:     weight_reg[KIND_ANGLE]  <= cfg_data;
                REG_COMPLETION_RADIX: radix_reg <= cfg_data[RADIX_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg    <= score_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/bsm_stack_ram.sv @@
module bsm_stack_ram
    import bsm_pkg::*;
(
    input  logic              clk,
    input  bsm_ram_req_t      req,
    output logic [KIND_W-1:0] rd_data
);

    logic [KIND_W-1:0] mem [STACK_DEPTH];
    logic [KIND_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bsm_checker.sv @@
`include "bracket_stack_matcher_defines.svh"

module bsm_checker
    import bsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `BSM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `BSM_ASSERT_NOW(a_corrupt_no_score, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[82:19] == 64'd0, "corrupt line carries a completion score")
    `BSM_ASSERT_NOW(a_clean_no_error, clk, rst_n, m_tvalid && !m_tdata[0], (m_tdata[2:1] == 2'd0) && (m_tdata[18:3] == 16'd0), "clean line carries an error kind or weight")
    `BSM_ASSERT_NEXT(a_line_end_stall, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input not held after a line-end beat")

endmodule

bind bracket_stack_matcher bsm_checker u_bsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
